FILE: src/iplf_pkg.sv
// ----------------------------------------------------------------------------
// iplf_pkg
// Shared widths, mode codes and pipeline types for the image placement block.
// ----------------------------------------------------------------------------
`default_nettype none

package iplf_pkg;

    localparam int DIM_BITS    = 16;
    localparam int FRAC_BITS   = 8;
    localparam int IN_W        = 16;
    localparam int FUNC_W      = 3;
    localparam int NUM_W       = 2 * DIM_BITS + FRAC_BITS;
    localparam int N_CELLS     = NUM_W;
    localparam int POS_W       = 41;
    localparam int SZ_W        = 40;
    localparam int CNT_W       = 16;
    localparam int IN_FLD_W    = 6 * IN_W;
    localparam int IN_TDATA_W  = ((IN_FLD_W + 7) / 8) * 8;
    localparam int OUT_FLD_W   = 2 * POS_W + 2 * SZ_W + 1 + 2 * CNT_W;
    localparam int OUT_TDATA_W = ((OUT_FLD_W + 7) / 8) * 8;

    localparam logic [FUNC_W-1:0] MODE_STRETCH = 3'd0;
    localparam logic [FUNC_W-1:0] MODE_CENTER  = 3'd1;
    localparam logic [FUNC_W-1:0] MODE_FIT     = 3'd2;
    localparam logic [FUNC_W-1:0] MODE_FILL    = 3'd3;
    localparam logic [FUNC_W-1:0] MODE_TILE    = 3'd4;

    typedef struct packed {
        logic [FUNC_W-1:0]      mode;
        logic                   deg;
        logic                   use_x;
        logic signed [IN_W-1:0] ox;
        logic signed [IN_W-1:0] oy;
        logic [DIM_BITS-1:0]    aw;
        logic [DIM_BITS-1:0]    ah;
        logic [DIM_BITS-1:0]    iw;
        logic [DIM_BITS-1:0]    ih;
    } t_side;

    typedef struct packed {
        logic [DIM_BITS-1:0] rem;
        logic [NUM_W-1:0]    nq;
        logic [DIM_BITS-1:0] dvs;
    } t_lane;

    typedef struct packed {
        logic  vld;
        t_side side;
        t_lane l0;
        t_lane l1;
    } t_stage;

    typedef struct packed {
        logic signed [POS_W-1:0] dx;
        logic signed [POS_W-1:0] dy;
        logic [SZ_W-1:0]         dw;
        logic [SZ_W-1:0]         dh;
        logic                    clip;
        logic [CNT_W-1:0]        cols;
        logic [CNT_W-1:0]        rows;
    } t_res;

endpackage

`default_nettype wire

FILE: src/iplf_prep.sv
// ----------------------------------------------------------------------------
// iplf_prep
// Input register, axis products and divider lane setup.
// ----------------------------------------------------------------------------
`default_nettype none

module iplf_prep
    import iplf_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic                i_vld,
    input  wire logic [FUNC_W-1:0]   i_func,
    input  wire logic [IN_W-1:0]     i_area_x,
    input  wire logic [IN_W-1:0]     i_area_y,
    input  wire logic [IN_W-1:0]     i_area_width,
    input  wire logic [IN_W-1:0]     i_area_height,
    input  wire logic [IN_W-1:0]     i_image_width,
    input  wire logic [IN_W-1:0]     i_image_height,
    output t_stage                   o_stg
);

    logic                    r_vld;
    t_side                   r_side;
    logic [2*DIM_BITS-1:0]   r_px;
    logic [2*DIM_BITS-1:0]   r_py;
    t_side                   n_side;
    logic [DIM_BITS-1:0]     aw, ah, iw, ih;
    logic                    x_smaller;
    logic                    use_x;
    logic [2*DIM_BITS-1:0]   prod;

    assign aw = i_area_width[DIM_BITS-1:0];
    assign ah = i_area_height[DIM_BITS-1:0];
    assign iw = i_image_width[DIM_BITS-1:0];
    assign ih = i_image_height[DIM_BITS-1:0];

    always_comb begin
        n_side       = '0;
        n_side.mode  = i_func;
        n_side.deg   = (aw == '0) || (ah == '0) || (iw == '0) || (ih == '0);
        n_side.ox    = i_area_x;
        n_side.oy    = i_area_y;
        n_side.aw    = aw;
        n_side.ah    = ah;
        n_side.iw    = iw;
        n_side.ih    = ih;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= n_side;
            r_px   <= aw * ih;
            r_py   <= ah * iw;
        end
    end

    assign x_smaller = r_px < r_py;
    assign use_x     = (r_side.mode == MODE_FIT) ? x_smaller : !x_smaller;
    assign prod      = use_x ? r_px : r_py;

    always_comb begin
        o_stg            = '0;
        o_stg.vld        = r_vld;
        o_stg.side       = r_side;
        o_stg.side.use_x = use_x;
        o_stg.l1.nq      = NUM_W'({1'b0, r_side.ah} + {1'b0, r_side.ih} - 1'b1);
        o_stg.l1.dvs     = r_side.ih;
        if (r_side.mode == MODE_TILE) begin
            o_stg.l0.nq  = NUM_W'({1'b0, r_side.aw} + {1'b0, r_side.iw} - 1'b1);
            o_stg.l0.dvs = r_side.iw;
        end else begin
            o_stg.l0.nq  = NUM_W'(prod) << FRAC_BITS;
            o_stg.l0.dvs = use_x ? r_side.iw : r_side.ih;
        end
    end

endmodule

`default_nettype wire

FILE: src/iplf_cell.sv
// ----------------------------------------------------------------------------
// iplf_cell
// One restoring division step on two lanes; carries the request alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module iplf_cell
    import iplf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  t_stage    i_stg,
    output t_stage    o_stg
);

    logic   r_vld;
    t_stage r_stg;
    t_stage n_stg;

    function automatic t_lane lane_step(input t_lane a);
        logic [DIM_BITS:0] t;
        logic              ge;
        t_lane             b;
        t      = {a.rem, a.nq[NUM_W-1]};
        ge     = t >= {1'b0, a.dvs};
        b.dvs  = a.dvs;
        b.rem  = ge ? DIM_BITS'(t - {1'b0, a.dvs}) : t[DIM_BITS-1:0];
        b.nq   = {a.nq[NUM_W-2:0], ge};
        return b;
    endfunction

    always_comb begin
        n_stg    = i_stg;
        n_stg.l0 = lane_step(i_stg.l0);
        n_stg.l1 = lane_step(i_stg.l1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_stg.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stg <= n_stg;
        end
    end

    always_comb begin
        o_stg     = r_stg;
        o_stg.vld = r_vld;
    end

endmodule

`default_nettype wire

FILE: src/iplf_post.sv
// ----------------------------------------------------------------------------
// iplf_post
// Mode selection, centering offsets and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module iplf_post
    import iplf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  t_stage    i_stg,
    output logic      o_vld,
    output t_res      o_res
);

    logic                    r_vld;
    t_res                    r_res;
    t_res                    n_res;
    t_side                   s;
    logic [SZ_W-1:0]         awf, ahf;
    logic signed [POS_W-1:0] bx, by;
    logic                    ctr;

    function automatic logic signed [POS_W-1:0] half_gap(
        input logic [SZ_W-1:0] area,
        input logic [SZ_W-1:0] sz
    );
        logic signed [SZ_W+1:0] diff;
        diff = $signed({2'b00, area}) - $signed({2'b00, sz});
        return POS_W'(diff >>> 1);
    endfunction

    assign s   = i_stg.side;
    assign awf = SZ_W'(s.aw) << FRAC_BITS;
    assign ahf = SZ_W'(s.ah) << FRAC_BITS;
    assign bx  = $signed({{(POS_W-IN_W){s.ox[IN_W-1]}}, s.ox}) <<< FRAC_BITS;
    assign by  = $signed({{(POS_W-IN_W){s.oy[IN_W-1]}}, s.oy}) <<< FRAC_BITS;

    always_comb begin
        n_res    = '0;
        n_res.dx = bx;
        n_res.dy = by;
        ctr      = 1'b0;
        if (!s.deg) begin
            case (s.mode)
                MODE_STRETCH: begin
                    n_res.dw = awf;
                    n_res.dh = ahf;
                end
                MODE_CENTER: begin
                    n_res.dw   = SZ_W'(s.iw) << FRAC_BITS;
                    n_res.dh   = SZ_W'(s.ih) << FRAC_BITS;
                    n_res.clip = (s.iw > s.aw) || (s.ih > s.ah);
                    ctr        = 1'b1;
                end
                MODE_TILE: begin
                    n_res.cols = i_stg.l0.nq[CNT_W-1:0];
                    n_res.rows = i_stg.l1.nq[CNT_W-1:0];
                end
                default: begin
                    if (s.use_x) begin
                        n_res.dw = awf;
                        n_res.dh = i_stg.l0.nq[SZ_W-1:0];
                    end else begin
                        n_res.dw = i_stg.l0.nq[SZ_W-1:0];
                        n_res.dh = ahf;
                    end
                    n_res.clip = s.mode != MODE_FIT;
                    ctr        = 1'b1;
                end
            endcase
        end
        if (ctr) begin
            n_res.dx = bx + half_gap(awf, n_res.dw);
            n_res.dy = by + half_gap(ahf, n_res.dh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_stg.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_vld = r_vld;
    assign o_res = r_res;

endmodule

`default_nettype wire

FILE: src/image_placement_fit_fill_tile.sv
// ----------------------------------------------------------------------------
// image_placement_fit_fill_tile
// Places an image in an area: stretch, center, fit, fill or tile count.
// ----------------------------------------------------------------------------
// Takes one transaction per cycle while no output transaction waits; each request
// passes one input stage, a chain of 40 divider cells giving one quotient bit each,
// and one output stage. The whole pipeline holds while an output transaction
// waits; s_axis_tready is low only then.
// ----------------------------------------------------------------------------
`default_nettype none

module image_placement_fit_fill_tile
    import iplf_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // func
    input  wire logic [FUNC_W-1:0]      s_axis_tuser,
    // area_x, area_y, area_width, area_height, image_width, image_height
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // dest_x, dest_y, dest_width, dest_height, clip, tile_cols, tile_rows
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

    logic   en;
    t_stage w_stg [N_CELLS+1];
    t_res   res;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    iplf_prep u_prep (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_vld          (s_axis_tvalid),
        .i_func         (s_axis_tuser),
        .i_area_x       (s_axis_tdata[15:0]),
        .i_area_y       (s_axis_tdata[31:16]),
        .i_area_width   (s_axis_tdata[47:32]),
        .i_area_height  (s_axis_tdata[63:48]),
        .i_image_width  (s_axis_tdata[79:64]),
        .i_image_height (s_axis_tdata[95:80]),
        .o_stg          (w_stg[0])
    );

    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        iplf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_stg   (w_stg[g]),
            .o_stg   (w_stg[g+1])
        );
    end

    iplf_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_stg   (w_stg[N_CELLS]),
        .o_vld   (m_axis_tvalid),
        .o_res   (res)
    );

    assign m_axis_tdata = OUT_TDATA_W'({res.rows, res.cols, res.clip, res.dh, res.dw,
                                        res.dy, res.dx});

`ifndef ASSERT_OFF
    a_stall_only_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without blocked output");

    a_tile_no_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && res.cols != '0) |-> (res.dw == '0 && res.dh == '0 && !res.clip))
        else $error("tile result carries a size");

    a_tile_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && res.cols != '0) |-> (res.rows != '0))
        else $error("tile columns without rows");
`endif

endmodule

`default_nettype wire

FILE: verif/iplf_checker.sv
// ----------------------------------------------------------------------------
// iplf_checker
// Watches both stream channels of the image placement block, computes the
// expected placement of every accepted request and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module iplf_checker
    import iplf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    input  wire logic                  i_s_tready,
    input  wire logic [FUNC_W-1:0]     i_s_tuser,
    input  wire logic [IN_TDATA_W-1:0] i_s_tdata,
    input  wire logic                  i_m_tvalid,
    input  wire logic                  i_m_tready,
    input  wire logic [OUT_TDATA_W-1:0] i_m_tdata,
    output int                         o_fail_cnt,
    output int                         o_pending,
    output int                         o_result_cnt
);

    t_res placement_q[$];

    function automatic longint half_floor(longint d);
        return d >>> 1;
    endfunction

    function automatic t_res place_image(logic [FUNC_W-1:0] md, logic [IN_TDATA_W-1:0] d);
        longint ox, oy, aw, ah, iw, ih, awf, ahf, dx, dy, dw, dh;
        logic clip, xs, ux;
        longint cols, rows;
        t_res r;
        ox = longint'($signed(d[15:0])) * 256;
        oy = longint'($signed(d[31:16])) * 256;
        aw = d[47:32];
        ah = d[63:48];
        iw = d[79:64];
        ih = d[95:80];
        dx = ox; dy = oy; dw = 0; dh = 0; clip = 0; cols = 0; rows = 0;
        if (aw != 0 && ah != 0 && iw != 0 && ih != 0) begin
            awf = aw * 256;
            ahf = ah * 256;
            if (md == MODE_STRETCH) begin
                dw = awf; dh = ahf;
            end else if (md == MODE_CENTER) begin
                dw = iw * 256; dh = ih * 256;
                dx = ox + half_floor(awf - dw);
                dy = oy + half_floor(ahf - dh);
                clip = (iw > aw) || (ih > ah);
            end else if (md == MODE_TILE) begin
                cols = (aw + iw - 1) / iw;
                rows = (ah + ih - 1) / ih;
            end else begin
                xs = (aw * ih) < (ah * iw);
                ux = (md == MODE_FIT) ? xs : !xs;
                if (ux) begin
                    dw = awf; dh = (ih * aw * 256) / iw;
                end else begin
                    dh = ahf; dw = (iw * ah * 256) / ih;
                end
                dx = ox + half_floor(awf - dw);
                dy = oy + half_floor(ahf - dh);
                clip = (md != MODE_FIT);
            end
        end
        r.dx = dx[POS_W-1:0];
        r.dy = dy[POS_W-1:0];
        r.dw = dw[SZ_W-1:0];
        r.dh = dh[SZ_W-1:0];
        r.clip = clip;
        r.cols = cols[CNT_W-1:0];
        r.rows = rows[CNT_W-1:0];
        return r;
    endfunction

    function automatic t_res unpack_result(logic [OUT_TDATA_W-1:0] d);
        t_res r;
        r.dx = d[40:0];
        r.dy = d[81:41];
        r.dw = d[121:82];
        r.dh = d[161:122];
        r.clip = d[162];
        r.cols = d[178:163];
        r.rows = d[194:179];
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        t_res got, want;
        if (!i_rst_n) begin
            o_fail_cnt <= 0;
            o_result_cnt <= 0;
            o_pending <= 0;
            placement_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                placement_q.push_back(place_image(i_s_tuser, i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got = unpack_result(i_m_tdata);
                o_result_cnt <= o_result_cnt + 1;
                if (placement_q.size() == 0) begin
                    if (o_fail_cnt < 10) $display("unexpected result %h", i_m_tdata);
                    o_fail_cnt <= o_fail_cnt + 1;
                end else begin
                    want = placement_q.pop_front();
                    if (got != want) begin
                        if (o_fail_cnt < 10) begin
                            $display("mismatch exp dx=%h dy=%h dw=%h dh=%h c=%b tc=%h tr=%h",
                                want.dx, want.dy, want.dw, want.dh, want.clip,
                                want.cols, want.rows);
                            $display("         act dx=%h dy=%h dw=%h dh=%h c=%b tc=%h tr=%h",
                                got.dx, got.dy, got.dw, got.dh, got.clip,
                                got.cols, got.rows);
                        end
                        o_fail_cnt <= o_fail_cnt + 1;
                    end
                end
            end
            o_pending <= placement_q.size();
        end
    end

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives directed and random placement requests into the image placement
// block with random idling on both sides and a long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import iplf_pkg::*;

    localparam int N_RANDOM = 1330;
    localparam int LIMIT    = 200000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [FUNC_W-1:0]      s_axis_tuser = '0;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    int fail_cnt, pending, result_cnt;
    int cycle = 0;
    bit hold_done = 1'b0;

    always #4 i_clk = ~i_clk;

    image_placement_fit_fill_tile DUT (.*);

    iplf_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready),
        .i_s_tuser(s_axis_tuser),
        .i_s_tdata(s_axis_tdata), .i_m_tvalid(m_axis_tvalid),
        .i_m_tready(m_axis_tready), .i_m_tdata(m_axis_tdata),
        .o_fail_cnt(fail_cnt), .o_pending(pending), .o_result_cnt(result_cnt)
    );

    function automatic logic [15:0] rand_dim();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'hFFFF;
            2, 3: return 16'($urandom_range(1, 16));
            4, 5: return 16'($urandom_range(1, 1024));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pack_req(
            logic [15:0] x, logic [15:0] y, logic [15:0] aw, logic [15:0] ah,
            logic [15:0] iw, logic [15:0] ih);
        return {ih, iw, ah, aw, y, x};
    endfunction

    task automatic send_req(logic [FUNC_W-1:0] md, logic [IN_TDATA_W-1:0] d);
        repeat ($urandom_range(0, 3)) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= md;
        s_axis_tdata <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > LIMIT) begin
            $display("timeout");
            $display("image_placement_fit_fill_tile verification failed");
            $finish;
        end
    end

    // receiver: long hold-off once, then random stalls
    initial begin
        int gap;
        repeat (5) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        hold_done = 1'b1;
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
            if (cycle > 3000 && cycle < 3600) gap = 0;
            m_axis_tready <= 1'b0;
            repeat (gap) @(posedge i_clk);
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    initial begin
        logic [2:0] md;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int m = 0; m < 8; m++) begin
            send_req(3'(m), pack_req(16'h8000, 16'h7FFF, 16'hFFFF, 16'd1, 16'd1, 16'hFFFF));
            send_req(3'(m), pack_req(16'h7FFF, 16'h8000, 16'd7, 16'd9, 16'd20, 16'd3));
        end
        send_req(MODE_FIT, pack_req(16'd0, 16'd0, 16'd0, 16'd10, 16'd10, 16'd10));
        send_req(MODE_TILE, pack_req(16'd5, 16'd5, 16'd10, 16'd0, 16'd10, 16'd10));
        send_req(MODE_FILL, pack_req(16'd1, 16'd1, 16'd10, 16'd10, 16'd0, 16'd10));
        send_req(MODE_CENTER, pack_req(16'd1, 16'd1, 16'd10, 16'd10, 16'd10, 16'd0));
        send_req(MODE_FIT, pack_req(16'd0, 16'd0, 16'd40, 16'd20, 16'd4, 16'd2));
        send_req(MODE_FILL, pack_req(16'd0, 16'd0, 16'd40, 16'd20, 16'd4, 16'd2));
        send_req(MODE_CENTER, pack_req(16'hFFFF, 16'hFFFF, 16'd3, 16'd4, 16'd4, 16'd3));
        send_req(MODE_TILE, pack_req(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1));
        send_req(MODE_STRETCH,
                 pack_req(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        for (int i = 0; i < N_RANDOM; i++) begin
            md = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
            send_req(md, pack_req(16'($urandom), 16'($urandom), rand_dim(),
                                  rand_dim(), rand_dim(), rand_dim()));
        end
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || !hold_done) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("placement requests in all eight mode codes, degenerate and extreme sizes;");
        $display("%0d results checked under random stalls and a long output hold-off", result_cnt);
        if (fail_cnt == 0 && pending == 0) begin
            $display("image_placement_fit_fill_tile verification clean");
        end else begin
            $display("image_placement_fit_fill_tile verification failed");
        end
        $finish;
    end

endmodule
